// ----- hw/rtl/fsq_pkg.sv -----
// shared types, codes and constants of the fastq splitter and base packer
package fsq_pkg;

   // widths of the stream payloads
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 32;
   localparam int RSP_KIND_W   = 3;
   localparam int COUNT_W_DEF  = 32;

   // results one request can cause, and the width of a result count
   localparam int MAX_RES      = 5;
   localparam int RES_NUM_W    = $clog2(MAX_RES + 1);

   // result kinds
   localparam logic [RSP_KIND_W-1:0] KIND_PACKED   = 3'd0;
   localparam logic [RSP_KIND_W-1:0] KIND_HEADER   = 3'd1;
   localparam logic [RSP_KIND_W-1:0] KIND_POSITION = 3'd2;
   localparam logic [RSP_KIND_W-1:0] KIND_DELIM    = 3'd3;
   localparam logic [RSP_KIND_W-1:0] KIND_QUALITY  = 3'd4;

   // special bytes and values
   localparam logic [REQ_DATA_W-1:0] CHAR_AT      = 8'h40;
   localparam logic [REQ_DATA_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [REQ_DATA_W-1:0] CHAR_NL      = 8'h0A;
   localparam logic [REQ_DATA_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [REQ_DATA_W-1:0] BASE_MASK    = 8'h60;
   localparam logic [RSP_DATA_W-1:0] DELIM_VALUE  = 32'hFFFF_FFFF;

   // one result
   typedef struct packed {
      logic [RSP_KIND_W-1:0] kind;
      logic [RSP_DATA_W-1:0] value;
   } rsp_ent_type;

   // all results of one request, entry 0 goes out first
   typedef struct packed {
      rsp_ent_type [MAX_RES-1:0] ent;
      logic [RES_NUM_W-1:0]      num;
   } rsp_batch_type;

endpackage

// ----- hw/rtl/fastq_split_and_2bit_pack.sv -----
// Splits a FASTQ byte stream into packed bases (four 2-bit codes per byte,
// first base high), header bytes ended by 0x00, position count plus
// delimiter at each header, and quality bytes ended by a newline; the kind
// of each result rides on rsp_tuser and rsp_tlast marks the last result of
// a request. A request is taken once the buffer is free or its last
// result goes out, and its results are ready the next cycle. Each
// request yields zero to five results and the single result port sends one
// per cycle while rsp_tready is high, so requests with zero or one result
// go at one per cycle. A request with req_tlast set flushes any partial
// base group and open line and returns the block to its reset state.
module fastq_split_and_2bit_pack import fsq_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // final_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] value
   output logic [RSP_KIND_W-1:0] rsp_tuser,   // [2:0] kind
   output logic                  rsp_tlast    // last_of_run
);

   rsp_batch_type batch;
   logic          accept;

   assign accept = req_tvalid & req_tready;

   // per-byte parsing and result list
   fsq_parse #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .batch      (batch)
   );

   // result buffer
   fsq_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .batch      (batch),
      .load_ok    (req_tready),
      .load       (accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hw/rtl/fsq_parse.sv -----
// line state, base grouping and per-byte result list of the fastq splitter
module fsq_parse import fsq_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [REQ_DATA_W-1:0] data_byte,
   input  logic                  final_byte,
   output rsp_batch_type         batch
);

   // line modes
   localparam logic [1:0] MODE_SEQ  = 2'd0;
   localparam logic [1:0] MODE_HDR  = 2'd1;
   localparam logic [1:0] MODE_SKIP = 2'd2;
   localparam logic [1:0] MODE_QUAL = 2'd3;

   localparam int CNT_EXT_W = (COUNT_WIDTH > RSP_DATA_W) ? COUNT_WIDTH : RSP_DATA_W;

   logic [1:0]             mode_ff,  mode_in;
   logic [5:0]             bits_ff,  bits_in;
   logic [1:0]             fill_ff,  fill_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   // partial group, zero padded in the low bits
   function automatic logic [7:0] close_byte(logic [5:0] bits, logic [1:0] fill);
      logic [7:0] res;
      case (fill)
         2'd1:    res = {bits[1:0], 6'b0};
         2'd2:    res = {bits[3:0], 4'b0};
         2'd3:    res = {bits, 2'b0};
         default: res = 8'h00;
      endcase
      return res;
   endfunction

   // result list and next state for the byte at the input
   always_comb begin
      logic [1:0]           code;
      logic [CNT_EXT_W-1:0] cnt_ext;
      code     = data_byte[2:1];
      batch    = '0;
      mode_in  = mode_ff;
      bits_in  = bits_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      cnt_ext  = '0;

      unique case (mode_ff)
         MODE_SEQ: begin
            if (data_byte == CHAR_AT || data_byte == CHAR_PLUS) begin
               if (fill_ff != 2'd0) begin
                  batch.ent[batch.num] = '{KIND_PACKED,
                                           RSP_DATA_W'(close_byte(bits_ff, fill_ff))};
                  batch.num = batch.num + 1'b1;
                  count_in  = count_in + COUNT_WIDTH'(1);
               end
               bits_in = '0;
               fill_in = '0;
               if (data_byte == CHAR_AT) begin
                  cnt_ext = CNT_EXT_W'(count_in);
                  batch.ent[batch.num] = '{KIND_POSITION, cnt_ext[RSP_DATA_W-1:0]};
                  batch.num = batch.num + 1'b1;
                  batch.ent[batch.num] = '{KIND_DELIM, DELIM_VALUE};
                  batch.num = batch.num + 1'b1;
                  batch.ent[batch.num] = '{KIND_HEADER, RSP_DATA_W'(data_byte)};
                  batch.num = batch.num + 1'b1;
                  mode_in = MODE_HDR;
               end else begin
                  mode_in = MODE_SKIP;
               end
            end else if ((data_byte & BASE_MASK) != '0) begin
               if (fill_ff == 2'd3) begin
                  batch.ent[batch.num] = '{KIND_PACKED, RSP_DATA_W'({bits_ff, code})};
                  batch.num = batch.num + 1'b1;
                  count_in  = count_in + COUNT_WIDTH'(1);
                  bits_in   = '0;
                  fill_in   = '0;
               end else begin
                  bits_in = {bits_ff[3:0], code};
                  fill_in = fill_ff + 2'd1;
               end
            end
         end
         MODE_HDR: begin
            if (data_byte == CHAR_NL) begin
               batch.ent[batch.num] = '{KIND_HEADER, RSP_DATA_W'(CHAR_NUL)};
               mode_in = MODE_SEQ;
            end else begin
               batch.ent[batch.num] = '{KIND_HEADER, RSP_DATA_W'(data_byte)};
            end
            batch.num = batch.num + 1'b1;
         end
         MODE_SKIP: begin
            if (data_byte == CHAR_NL) begin
               mode_in = MODE_QUAL;
            end
         end
         MODE_QUAL: begin
            // a newline copies through as the line end
            batch.ent[batch.num] = '{KIND_QUALITY, RSP_DATA_W'(data_byte)};
            batch.num = batch.num + 1'b1;
            if (data_byte == CHAR_NL) begin
               mode_in = MODE_SEQ;
            end
         end
         default: begin
            mode_in = MODE_SEQ;
         end
      endcase

      // end of file: flush open work and start over
      if (final_byte) begin
         if (fill_in != 2'd0) begin
            batch.ent[batch.num] = '{KIND_PACKED,
                                     RSP_DATA_W'(close_byte(bits_in, fill_in))};
            batch.num = batch.num + 1'b1;
         end
         if (mode_in == MODE_HDR) begin
            batch.ent[batch.num] = '{KIND_HEADER, RSP_DATA_W'(CHAR_NUL)};
            batch.num = batch.num + 1'b1;
         end else if (mode_in == MODE_SKIP || mode_in == MODE_QUAL) begin
            batch.ent[batch.num] = '{KIND_QUALITY, RSP_DATA_W'(CHAR_NL)};
            batch.num = batch.num + 1'b1;
         end
         mode_in  = MODE_SEQ;
         bits_in  = '0;
         fill_in  = '0;
         count_in = '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SEQ;
         bits_ff  <= '0;
         fill_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         bits_ff  <= bits_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/fsq_outq.sv -----
// result buffer that hands one request's results out one per cycle while rsp_tready is high
module fsq_outq import fsq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  rsp_batch_type         batch,
   output logic                  load_ok,
   input  logic                  load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_KIND_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   rsp_ent_type [MAX_RES-1:0] ent_ff, ent_in;
   logic [RES_NUM_W-1:0]      num_ff, num_in;
   logic                      take;

   assign take       = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (num_ff != '0);
   assign rsp_tdata  = ent_ff[0].value;
   assign rsp_tuser  = ent_ff[0].kind;
   assign rsp_tlast  = (num_ff == RES_NUM_W'(1));

   // free now, or free after the last result goes this cycle
   assign load_ok = (num_ff == '0) | (take & rsp_tlast);

   // load a new list or shift the taken result out
   always_comb begin
      ent_in = ent_ff;
      num_in = num_ff;
      if (load) begin
         ent_in = batch.ent;
         num_in = batch.num;
      end else if (take) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            ent_in[i] = ent_ff[i+1];
         end
         ent_in[MAX_RES-1] = '0;
         num_in = num_ff - 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
      end else begin
         num_ff <= num_in;
      end
   end

endmodule

// ----- hw/rtl/fsq_checker.sv -----
// port-level checks of the fastq splitter, bound to the top level
module fsq_checker import fsq_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_KIND_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a new request only enters once the pending list is finishing
   assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tready && rsp_tlast)
      else $error("request taken while results pending");

   // more results of the same request follow a non-last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("result list cut short");

   // a position never ends a result list, so its delimiter can follow
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_POSITION |-> !rsp_tlast)
      else $error("position ends a result list");

   // the delimiter carries all ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DELIM |-> rsp_tdata == DELIM_VALUE)
      else $error("bad delimiter value");

endmodule

bind fastq_split_and_2bit_pack fsq_checker u_fsq_checker (.*);
